// ===== rtl/hsf_pkg.sv =====
// hsf_pkg: types and constants for the HID report SOCD filter.
// No dependencies; used by hsf_pair, hsf_filter, hid_report_socd_filter and hsf_checker.
`default_nettype none
package hsf_pkg;

  localparam int unsigned NKEYS      = 6;
  localparam int unsigned SLOT_COUNT = 3;
  localparam int unsigned POS_W      = $clog2(NKEYS);

  localparam logic [7:0] CTRL_MASK    = 8'h11;
  localparam logic [7:0] USAGE_DIGIT1 = 8'h1E;
  localparam logic [7:0] USAGE_DIGITN = 8'(USAGE_DIGIT1 + SLOT_COUNT - 1);
  localparam logic [7:0] USAGE_A      = 8'h04;
  localparam logic [7:0] USAGE_D      = 8'h07;
  localparam logic [7:0] USAGE_S      = 8'h16;
  localparam logic [7:0] USAGE_W      = 8'h1A;
  localparam logic [7:0] USAGE_RIGHT  = 8'h4F;
  localparam logic [7:0] USAGE_LEFT   = 8'h50;
  localparam logic [7:0] USAGE_DOWN   = 8'h51;
  localparam logic [7:0] USAGE_UP     = 8'h52;

  localparam logic [1:0] WIN_NONE = 2'd0;
  localparam logic [1:0] WIN_LO   = 2'd1;
  localparam logic [1:0] WIN_HI   = 2'd2;

  typedef logic [NKEYS-1:0][7:0] keys_t;

  typedef struct packed {
    logic [7:0] modifier_bits;
    keys_t      keys;
  } report_t;

  typedef struct packed {
    logic       forwarded;
    logic [7:0] modifier_bits;
    keys_t      keys;
    logic       switch_request;
    logic [3:0] switch_slot;
  } result_t;

  typedef struct packed {
    logic       prev_left;
    logic       prev_right;
    logic       prev_up;
    logic       prev_down;
    logic [1:0] h_winner;
    logic [1:0] v_winner;
  } socd_state_t;

  typedef struct packed {
    logic             lo_hit;
    logic             hi_hit;
    logic [POS_W-1:0] lo_pos;
    logic [POS_W-1:0] hi_pos;
    logic             prev_lo;
    logic             prev_hi;
    logic [1:0]       winner;
  } pair_in_t;

endpackage
`default_nettype wire

// ===== rtl/hsf_if.sv =====
// hsf_report_if / hsf_result_if: valid/ready channels of the SOCD filter.
// Depends on nothing; payload fields match the report and result items.
`default_nettype none
interface hsf_report_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifier_bits;
  logic [7:0] key_0;
  logic [7:0] key_1;
  logic [7:0] key_2;
  logic [7:0] key_3;
  logic [7:0] key_4;
  logic [7:0] key_5;

  modport source (output valid, modifier_bits, key_0, key_1, key_2, key_3, key_4, key_5,
                  input ready);
  modport sink (input valid, modifier_bits, key_0, key_1, key_2, key_3, key_4, key_5,
                output ready);
endinterface

interface hsf_result_if;
  logic       valid;
  logic       ready;
  logic       forwarded;
  logic [7:0] out_modifier_bits;
  logic [7:0] out_key_0;
  logic [7:0] out_key_1;
  logic [7:0] out_key_2;
  logic [7:0] out_key_3;
  logic [7:0] out_key_4;
  logic [7:0] out_key_5;
  logic       switch_request;
  logic [3:0] switch_slot;

  modport source (output valid, forwarded, out_modifier_bits, out_key_0, out_key_1,
                  out_key_2, out_key_3, out_key_4, out_key_5, switch_request,
                  switch_slot, input ready);
  modport sink (input valid, forwarded, out_modifier_bits, out_key_0, out_key_1,
                out_key_2, out_key_3, out_key_4, out_key_5, switch_request,
                switch_slot, output ready);
endinterface
`default_nettype wire

// ===== rtl/hsf_pair.sv =====
// hsf_pair: last-win resolution of one opposing key pair.
// Depends on hsf_pkg.
`default_nettype none
module hsf_pair (
  input  hsf_pkg::pair_in_t              pin,
  output logic [1:0]                     winner_nxt,
  output logic [hsf_pkg::NKEYS-1:0]      clear_mask
);
  import hsf_pkg::*;

  logic [1:0] win;

  always_comb begin
    win = pin.winner;
    if (!pin.prev_lo && pin.prev_hi) begin
      win = WIN_LO;
    end else if (pin.prev_lo != pin.prev_hi) begin
      win = WIN_HI;
    end else if (!pin.prev_lo) begin
      win = WIN_HI;
    end
    if (pin.lo_hit && pin.hi_hit) begin
      winner_nxt = win;
      if (win == WIN_LO) begin
        clear_mask = NKEYS'(1) << pin.hi_pos;
      end else begin
        clear_mask = NKEYS'(1) << pin.lo_pos;
      end
    end else begin
      winner_nxt = WIN_NONE;
      clear_mask = '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hsf_filter.sv =====
// hsf_filter: switch-combo detection and SOCD cleaning of one report.
// Depends on hsf_pkg and hsf_pair.
`default_nettype none
module hsf_filter (
  input  hsf_pkg::report_t     rpt,
  input  logic                 switch_enable,
  input  hsf_pkg::socd_state_t st,
  output hsf_pkg::result_t     res,
  output hsf_pkg::socd_state_t st_nxt
);
  import hsf_pkg::*;

  logic             digit_hit;
  logic [3:0]       digit_slot;
  logic             consume;
  logic             l_hit, r_hit, u_hit, d_hit;
  logic [POS_W-1:0] l_pos, r_pos, u_pos, d_pos;
  pair_in_t         h_in, v_in;
  logic [1:0]       h_win, v_win;
  logic [NKEYS-1:0] h_clr, v_clr;

  always_comb begin
    digit_hit  = 1'b0;
    digit_slot = '0;
    l_hit = 1'b0; r_hit = 1'b0; u_hit = 1'b0; d_hit = 1'b0;
    l_pos = '0;   r_pos = '0;   u_pos = '0;   d_pos = '0;
    for (int i = 0; i < NKEYS; i++) begin
      if (rpt.keys[i] >= USAGE_DIGIT1 && rpt.keys[i] <= USAGE_DIGITN) begin
        digit_hit  = 1'b1;
        digit_slot = 4'(rpt.keys[i] - USAGE_DIGIT1);
      end
      if (rpt.keys[i] == USAGE_A || rpt.keys[i] == USAGE_LEFT) begin
        l_hit = 1'b1;
        l_pos = POS_W'(i);
      end
      if (rpt.keys[i] == USAGE_D || rpt.keys[i] == USAGE_RIGHT) begin
        r_hit = 1'b1;
        r_pos = POS_W'(i);
      end
      if (rpt.keys[i] == USAGE_W || rpt.keys[i] == USAGE_UP) begin
        u_hit = 1'b1;
        u_pos = POS_W'(i);
      end
      if (rpt.keys[i] == USAGE_S || rpt.keys[i] == USAGE_DOWN) begin
        d_hit = 1'b1;
        d_pos = POS_W'(i);
      end
    end
  end

  assign consume = switch_enable && (|(rpt.modifier_bits & CTRL_MASK)) && digit_hit;

  assign h_in = '{lo_hit: l_hit, hi_hit: r_hit, lo_pos: l_pos, hi_pos: r_pos,
                  prev_lo: st.prev_left, prev_hi: st.prev_right, winner: st.h_winner};
  assign v_in = '{lo_hit: u_hit, hi_hit: d_hit, lo_pos: u_pos, hi_pos: d_pos,
                  prev_lo: st.prev_up, prev_hi: st.prev_down, winner: st.v_winner};

  hsf_pair u_pair_h (.pin(h_in), .winner_nxt(h_win), .clear_mask(h_clr));
  hsf_pair u_pair_v (.pin(v_in), .winner_nxt(v_win), .clear_mask(v_clr));

  always_comb begin
    if (consume) begin
      res    = '0;
      res.switch_request = 1'b1;
      res.switch_slot    = digit_slot;
      st_nxt = st;
    end else begin
      res.forwarded      = 1'b1;
      res.modifier_bits  = rpt.modifier_bits;
      res.switch_request = 1'b0;
      res.switch_slot    = '0;
      for (int i = 0; i < NKEYS; i++) begin
        res.keys[i] = (h_clr[i] || v_clr[i]) ? 8'h00 : rpt.keys[i];
      end
      st_nxt = '{prev_left: l_hit, prev_right: r_hit, prev_up: u_hit,
                 prev_down: d_hit, h_winner: h_win, v_winner: v_win};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hid_report_socd_filter.sv =====
// hid_report_socd_filter: top level; input register, filter logic, result register.
// Depends on hsf_pkg, hsf_if (hsf_report_if, hsf_result_if) and hsf_filter.
//
//   channel  | dir | handshake       | content
//   in_rpt   | in  | valid/ready     | modifier byte, six key codes
//   out_res  | out | valid/ready     | forwarded flag, cleaned report, switch request
//   cfg_*    | in  | cfg_we (no ack) | switch_enable
//
// Input register, then result register; one item per cycle sustained while out_res.ready stays high.
// The SOCD state updates when an item moves from the input register into the
// result register, so items are cleaned strictly in arrival order.
// A stalled result holds the result register; the input register fills behind it.
// rst_n is synchronous and clears both valid flags, the SOCD state and sets switch_enable.
`default_nettype none
module hid_report_socd_filter (
  input  logic                clk,
  input  logic                rst_n,
  hsf_report_if.sink          in_rpt,
  hsf_result_if.source        out_res,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import hsf_pkg::*;

  logic        in_v_r, in_v_nxt;
  report_t     rpt_r;
  logic        out_v_r, out_v_nxt;
  result_t     res_r;
  socd_state_t st_r, st_nxt;
  logic        sw_en_r;
  logic        in_acc, adv;
  result_t     res_c;

  assign adv    = in_v_r && (!out_v_r || out_res.ready);
  assign in_rpt.ready = !in_v_r || !out_v_r || out_res.ready;
  assign in_acc = in_rpt.valid && in_rpt.ready;

  assign in_v_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : in_v_r);
  assign out_v_nxt = adv ? 1'b1 : (out_res.ready ? 1'b0 : out_v_r);

  hsf_filter u_filter (
    .rpt           (rpt_r),
    .switch_enable (sw_en_r),
    .st            (st_r),
    .res           (res_c),
    .st_nxt        (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= '0;
      sw_en_r <= 1'b1;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
      if (cfg_we) begin
        sw_en_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rpt_r <= '{modifier_bits: in_rpt.modifier_bits,
                 keys: {in_rpt.key_5, in_rpt.key_4, in_rpt.key_3,
                        in_rpt.key_2, in_rpt.key_1, in_rpt.key_0}};
    end
    if (adv) begin
      res_r <= res_c;
    end
  end

  assign out_res.valid             = out_v_r;
  assign out_res.forwarded         = res_r.forwarded;
  assign out_res.out_modifier_bits = res_r.modifier_bits;
  assign out_res.out_key_0         = res_r.keys[0];
  assign out_res.out_key_1         = res_r.keys[1];
  assign out_res.out_key_2         = res_r.keys[2];
  assign out_res.out_key_3         = res_r.keys[3];
  assign out_res.out_key_4         = res_r.keys[4];
  assign out_res.out_key_5         = res_r.keys[5];
  assign out_res.switch_request    = res_r.switch_request;
  assign out_res.switch_slot       = res_r.switch_slot;

endmodule
`default_nettype wire

// ===== rtl/hsf_checker.sv =====
// hsf_checker: port-level assertions on the SOCD filter result channel.
// Depends on hsf_pkg; bound to hid_report_socd_filter below.
`default_nettype none
module hsf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       forwarded,
  input logic [7:0] out_modifier_bits,
  input logic [7:0] out_key_0,
  input logic [7:0] out_key_1,
  input logic [7:0] out_key_2,
  input logic [7:0] out_key_3,
  input logic [7:0] out_key_4,
  input logic [7:0] out_key_5,
  input logic       switch_request,
  input logic [3:0] switch_slot
);
  import hsf_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (forwarded != switch_request))
    else $error("item neither forwarded nor switch request");

  a_consumed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && switch_request) |-> (out_modifier_bits == 8'h00 && out_key_0 == 8'h00 &&
      out_key_1 == 8'h00 && out_key_2 == 8'h00 && out_key_3 == 8'h00 &&
      out_key_4 == 8'h00 && out_key_5 == 8'h00 && switch_slot < 4'(SLOT_COUNT)))
    else $error("consumed item carries report data or bad slot");

  a_fwd_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && forwarded) |-> (switch_slot == 4'd0))
    else $error("forwarded item carries a slot");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(forwarded) && $stable(switch_slot)))
    else $error("stalled item changed");

endmodule

bind hid_report_socd_filter hsf_checker u_hsf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_res.valid),
  .out_ready         (out_res.ready),
  .forwarded         (out_res.forwarded),
  .out_modifier_bits (out_res.out_modifier_bits),
  .out_key_0         (out_res.out_key_0),
  .out_key_1         (out_res.out_key_1),
  .out_key_2         (out_res.out_key_2),
  .out_key_3         (out_res.out_key_3),
  .out_key_4         (out_res.out_key_4),
  .out_key_5         (out_res.out_key_5),
  .switch_request    (out_res.switch_request),
  .switch_slot       (out_res.switch_slot)
);
`default_nettype wire
